FILE: rtl/core/assert_macros.svh
// Assertion helpers; the using module supplies clk and arst_n.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Antecedent implies consequent in the same cycle.
`define FBJS_ASSERT_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) else $error(msg);

// Condition must never hold.
`define FBJS_ASSERT_NEVER(lbl, cond, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) !(cond)) else $error(msg);

`endif

FILE: rtl/core/fbjs_pkg.sv
`default_nettype none
package fbjs_pkg;

	localparam int MAX_JOBS  = 8;
	localparam int JOB_W     = 3;
	localparam int CNT_W     = 4;
	localparam int TIME_BITS = 20;
	localparam int FC_W      = TIME_BITS + 1;
	localparam logic [15:0] PASS_LIMIT = 16'hFFFF;

	typedef enum logic [1:0] {
		FN_TICK  = 2'd0,
		FN_RUN   = 2'd1,
		FN_FRAME = 2'd2,
		FN_SETUP = 2'd3
	} func_t;

	typedef enum logic [1:0] {
		CFG_BUDGET = 2'd0,
		CFG_PERIOD = 2'd1,
		CFG_ACTIVE = 2'd2
	} cfg_idx_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_RPT_WR,
		ST_TK_SCHED,
		ST_TK_SDIV,
		ST_TK_RD,
		ST_TK_MOD,
		ST_TK_JDIV,
		ST_RK_LD,
		ST_RK_CMP,
		ST_PS_RD,
		ST_PS_WR,
		ST_OUT_RD,
		ST_OUT_LD,
		ST_OUT_WAIT
	} state_t;

	typedef struct packed {
		logic [TIME_BITS-1:0] target;
		logic [TIME_BITS-1:0] minimum;
		logic [TIME_BITS-1:0] cost;
		logic [31:0]          elapsed;
		logic [31:0]          run_sum;
		logic [15:0]          tally;
		logic [15:0]          grant;
	} job_rec_t;

	typedef struct packed {
		logic             rd_en;
		logic [JOB_W-1:0] rd_addr;
		logic             wr_en;
		logic [JOB_W-1:0] wr_addr;
		job_rec_t         wr_data;
	} mem_req_t;

	function automatic logic [31:0] sat_add32(input logic [31:0] a, input logic [31:0] b);
		logic [32:0] s;
		s = {1'b0, a} + {1'b0, b};
		return s[32] ? 32'hFFFF_FFFF : s[31:0];
	endfunction

	function automatic logic [15:0] sat_inc16(input logic [15:0] a);
		return (a == 16'hFFFF) ? a : a + 16'd1;
	endfunction

	function automatic logic [TIME_BITS-1:0] sat_cost(input logic [31:0] q);
		return (q > 32'((64'd1 << TIME_BITS) - 64'd1)) ? {TIME_BITS{1'b1}} : q[TIME_BITS-1:0];
	endfunction

endpackage
`default_nettype wire

FILE: rtl/core/frame_budget_job_scheduler.sv
// Frame budget job scheduler.
// Input channel in_valid/in_ready carries one command per transfer: func selects
// tick, job run report, frame report or job setup. in_ready is high only while
// the sequencer is idle. Reports and setups give no result.
// A tick gives one result per active job on out_valid/out_ready, jobs in
// ascending order, last set on the final one; with no active jobs it gives none.
// A tick steps through the jobs, with a serial divide on an averaging tick for
// the scheduler and for each job with a nonzero tally, then ranks the jobs,
// runs the grant passes and gives the results. The job memory has one read
// port and one write port, one access each per cycle.
// A stalled receiver holds the sequencer until the result transfers.
// Configuration writes on cfg_we/cfg_index/cfg_data take effect at once; the
// user must make them only while idle, which the block does not enforce.
// Reset empties the job memory, clears the sums and counts and loads the
// register defaults; the block is ready as soon as reset ends.
`default_nettype none
module frame_budget_job_scheduler (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        in_valid,
	output logic             in_ready,
	input  wire logic [1:0]  func,
	input  wire logic [19:0] delta_us,
	input  wire logic [2:0]  job_index,
	input  wire logic [19:0] measured_us,
	input  wire logic [19:0] target_period_us,
	input  wire logic [19:0] minimum_period_us,
	output logic             out_valid,
	input  wire logic        out_ready,
	output logic [2:0]       out_job,
	output logic [15:0]      run_count,
	output logic             last,
	input  wire logic        cfg_we,
	input  wire logic [1:0]  cfg_index,
	input  wire logic [19:0] cfg_data
);

	`include "assert_macros.svh"

	localparam int TB = fbjs_pkg::TIME_BITS;
	localparam int JW = fbjs_pkg::JOB_W;
	localparam int CW = fbjs_pkg::CNT_W;
	localparam int FW = fbjs_pkg::FC_W;

	fbjs_pkg::state_t state_q, state_d;

	logic [TB-1:0] budget_q, period_q;
	logic [3:0]    active_q;
	logic [TB-1:0] sched_cost_q;
	logic [31:0]   sched_sum_q;
	logic [15:0]   sched_tally_q;
	logic [31:0]   second_q;

	logic [19:0]   delta_q, meas_q;
	logic [JW-1:0] jidx_q;
	logic          reb_q;
	logic [CW-1:0] i_q, j_q, k_q, rank_q;
	logic [15:0]   pass_q;
	logic          work_q;
	logic [FW-1:0] fc_q;
	logic [31:0]   keyi_q;
	logic [31:0]   key_q [fbjs_pkg::MAX_JOBS];
	logic [JW-1:0] order_q [fbjs_pkg::MAX_JOBS];

	logic          out_valid_q, last_q;
	logic [2:0]    out_job_q;
	logic [15:0]   run_count_q;

	fbjs_pkg::mem_req_t mem_req;
	fbjs_pkg::job_rec_t rec;
	logic          div_start, div_done;
	logic [31:0]   div_dividend, div_q;
	logic [15:0]   div_divisor;

	logic [CW-1:0] n_jobs;
	logic          accept;
	logic [31:0]   se_sum;
	logic [31:0]   el_add;
	logic [TB-1:0] thr;
	logic          elig, below, over_thr, grant_now, zero_el;
	logic [FW:0]   fc_sum;
	logic [FW-1:0] fc_new;
	logic [31:0]   new_el;
	logic [JW-1:0] key_addr;
	logic [31:0]   key_rd;
	logic          beats;
	logic [CW-1:0] rank_new;
	logic          i_last, j_last, k_last;

	fbjs_mem u_mem (
		.clk     (clk),
		.arst_n  (arst_n),
		.req     (mem_req),
		.rd_data (rec)
	);

	fbjs_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (div_dividend),
		.divisor  (div_divisor),
		.done     (div_done),
		.quotient (div_q)
	);

	assign n_jobs = (active_q > 4'(fbjs_pkg::MAX_JOBS)) ? CW'(fbjs_pkg::MAX_JOBS) : active_q;
	assign accept = in_valid && in_ready;
	assign se_sum = fbjs_pkg::sat_add32(second_q, 32'(delta_us));
	assign el_add = fbjs_pkg::sat_add32(rec.elapsed, 32'(delta_q));
	assign thr    = (sched_cost_q < budget_q) ? sched_cost_q : budget_q;

	assign i_last = (i_q + CW'(1)) == n_jobs;
	assign j_last = (j_q + CW'(1)) == n_jobs;
	assign k_last = (k_q + CW'(1)) == n_jobs;

	// grant evaluation for one job of a pass
	assign elig      = (rec.target != '0) && (rec.elapsed >= 32'(rec.target));
	assign below     = rec.elapsed < 32'(rec.minimum);
	assign over_thr  = (fc_q != '0) && (fc_q > FW'(thr));
	assign grant_now = elig && !(below && over_thr);
	assign fc_sum    = {1'b0, fc_q} + (FW + 1)'(rec.cost);
	assign fc_new    = (fc_sum > (FW + 1)'(1 << TB)) ? FW'(1 << TB) : fc_sum[FW-1:0];
	assign zero_el   = !below && (fc_new > FW'(budget_q));
	assign new_el    = zero_el ? '0 : rec.elapsed - 32'(rec.target);

	assign key_addr = (state_q == fbjs_pkg::ST_RK_LD) ? i_q[JW-1:0] : j_q[JW-1:0];
	assign key_rd   = key_q[key_addr];
	assign beats    = (key_rd > keyi_q) || ((key_rd == keyi_q) && (j_q > i_q));
	assign rank_new = rank_q + CW'(beats);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= fbjs_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d      = state_q;
		in_ready     = 1'b0;
		mem_req      = '0;
		div_start    = 1'b0;
		div_dividend = sched_sum_q;
		div_divisor  = sched_tally_q;
		case (state_q)
			fbjs_pkg::ST_IDLE: begin
				in_ready = 1'b1;
				if (accept) begin
					case (fbjs_pkg::func_t'(func))
						fbjs_pkg::FN_TICK: state_d = fbjs_pkg::ST_TK_SCHED;
						fbjs_pkg::FN_RUN: begin
							mem_req.rd_en   = 1'b1;
							mem_req.rd_addr = job_index;
							state_d         = fbjs_pkg::ST_RPT_WR;
						end
						fbjs_pkg::FN_SETUP: begin
							mem_req.wr_en           = 1'b1;
							mem_req.wr_addr         = job_index;
							mem_req.wr_data.target  = target_period_us;
							mem_req.wr_data.minimum = minimum_period_us;
						end
						default: ;
					endcase
				end
			end
			fbjs_pkg::ST_RPT_WR: begin
				mem_req.wr_en           = 1'b1;
				mem_req.wr_addr         = jidx_q;
				mem_req.wr_data         = rec;
				mem_req.wr_data.run_sum = fbjs_pkg::sat_add32(rec.run_sum, 32'(meas_q));
				mem_req.wr_data.tally   = fbjs_pkg::sat_inc16(rec.tally);
				state_d                 = fbjs_pkg::ST_IDLE;
			end
			fbjs_pkg::ST_TK_SCHED: begin
				if (reb_q && sched_tally_q != '0) begin
					div_start = 1'b1;
					state_d   = fbjs_pkg::ST_TK_SDIV;
				end else begin
					state_d = (n_jobs == '0) ? fbjs_pkg::ST_IDLE : fbjs_pkg::ST_TK_RD;
				end
			end
			fbjs_pkg::ST_TK_SDIV: begin
				if (div_done) begin
					state_d = (n_jobs == '0) ? fbjs_pkg::ST_IDLE : fbjs_pkg::ST_TK_RD;
				end
			end
			fbjs_pkg::ST_TK_RD: begin
				mem_req.rd_en   = 1'b1;
				mem_req.rd_addr = i_q[JW-1:0];
				state_d         = fbjs_pkg::ST_TK_MOD;
			end
			fbjs_pkg::ST_TK_MOD, fbjs_pkg::ST_TK_JDIV: begin
				div_dividend = rec.run_sum;
				div_divisor  = rec.tally;
				if (state_q == fbjs_pkg::ST_TK_MOD && reb_q && rec.tally != '0) begin
					div_start = 1'b1;
					state_d   = fbjs_pkg::ST_TK_JDIV;
				end else if (state_q == fbjs_pkg::ST_TK_MOD || div_done) begin
					mem_req.wr_en           = 1'b1;
					mem_req.wr_addr         = i_q[JW-1:0];
					mem_req.wr_data         = rec;
					mem_req.wr_data.elapsed = el_add;
					mem_req.wr_data.grant   = '0;
					if (state_q == fbjs_pkg::ST_TK_JDIV) begin
						mem_req.wr_data.cost    = fbjs_pkg::sat_cost(div_q);
						mem_req.wr_data.run_sum = '0;
						mem_req.wr_data.tally   = '0;
					end
					state_d = i_last ? fbjs_pkg::ST_RK_LD : fbjs_pkg::ST_TK_RD;
				end
			end
			fbjs_pkg::ST_RK_LD: state_d = fbjs_pkg::ST_RK_CMP;
			fbjs_pkg::ST_RK_CMP: begin
				if (j_last) begin
					state_d = i_last ? fbjs_pkg::ST_PS_RD : fbjs_pkg::ST_RK_LD;
				end
			end
			fbjs_pkg::ST_PS_RD: begin
				mem_req.rd_en   = 1'b1;
				mem_req.rd_addr = order_q[k_q[JW-1:0]];
				state_d         = fbjs_pkg::ST_PS_WR;
			end
			fbjs_pkg::ST_PS_WR: begin
				if (grant_now) begin
					mem_req.wr_en           = 1'b1;
					mem_req.wr_addr         = order_q[k_q[JW-1:0]];
					mem_req.wr_data         = rec;
					mem_req.wr_data.grant   = rec.grant + 16'd1;
					mem_req.wr_data.elapsed = new_el;
				end
				if (k_last && !((work_q || grant_now) && (pass_q + 16'd1) != fbjs_pkg::PASS_LIMIT)) begin
					state_d = fbjs_pkg::ST_OUT_RD;
				end else begin
					state_d = fbjs_pkg::ST_PS_RD;
				end
			end
			fbjs_pkg::ST_OUT_RD: begin
				mem_req.rd_en   = 1'b1;
				mem_req.rd_addr = i_q[JW-1:0];
				state_d         = fbjs_pkg::ST_OUT_LD;
			end
			fbjs_pkg::ST_OUT_LD: state_d = fbjs_pkg::ST_OUT_WAIT;
			fbjs_pkg::ST_OUT_WAIT: begin
				if (out_ready) begin
					state_d = i_last ? fbjs_pkg::ST_IDLE : fbjs_pkg::ST_OUT_RD;
				end
			end
			default: state_d = fbjs_pkg::ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			budget_q      <= TB'(16667);
			period_q      <= TB'(1000000);
			active_q      <= '0;
			sched_cost_q  <= '0;
			sched_sum_q   <= '0;
			sched_tally_q <= '0;
			second_q      <= '0;
			reb_q         <= 1'b0;
			i_q           <= '0;
			j_q           <= '0;
			k_q           <= '0;
			rank_q        <= '0;
			pass_q        <= '0;
			work_q        <= 1'b0;
			fc_q          <= '0;
			out_valid_q   <= 1'b0;
		end else begin
			if (cfg_we) begin
				case (fbjs_pkg::cfg_idx_t'(cfg_index))
					fbjs_pkg::CFG_BUDGET: budget_q <= cfg_data;
					fbjs_pkg::CFG_PERIOD: period_q <= cfg_data;
					fbjs_pkg::CFG_ACTIVE: active_q <= cfg_data[3:0];
					default: ;
				endcase
			end
			case (state_q)
				fbjs_pkg::ST_IDLE: begin
					i_q <= '0;
					if (accept && fbjs_pkg::func_t'(func) == fbjs_pkg::FN_TICK) begin
						reb_q    <= se_sum >= 32'(period_q);
						second_q <= (se_sum >= 32'(period_q)) ? '0 : se_sum;
					end
					if (accept && fbjs_pkg::func_t'(func) == fbjs_pkg::FN_FRAME) begin
						sched_sum_q   <= fbjs_pkg::sat_add32(sched_sum_q, 32'(measured_us));
						sched_tally_q <= fbjs_pkg::sat_inc16(sched_tally_q);
					end
				end
				fbjs_pkg::ST_TK_SDIV: begin
					if (div_done) begin
						sched_cost_q  <= fbjs_pkg::sat_cost(div_q);
						sched_sum_q   <= '0;
						sched_tally_q <= '0;
					end
				end
				fbjs_pkg::ST_TK_MOD, fbjs_pkg::ST_TK_JDIV: begin
					if (state_d != fbjs_pkg::ST_TK_JDIV && state_d != state_q) begin
						i_q <= i_last ? '0 : i_q + CW'(1);
					end
				end
				fbjs_pkg::ST_RK_LD: begin
					j_q    <= '0;
					rank_q <= '0;
				end
				fbjs_pkg::ST_RK_CMP: begin
					j_q    <= j_q + CW'(1);
					rank_q <= rank_new;
					if (j_last) begin
						i_q    <= i_last ? '0 : i_q + CW'(1);
						k_q    <= '0;
						pass_q <= '0;
						work_q <= 1'b0;
						fc_q   <= '0;
					end
				end
				fbjs_pkg::ST_PS_WR: begin
					if (grant_now) begin
						fc_q <= fc_new;
					end
					if (k_last) begin
						k_q    <= '0;
						work_q <= 1'b0;
						pass_q <= pass_q + 16'd1;
					end else begin
						k_q    <= k_q + CW'(1);
						work_q <= work_q || grant_now;
					end
				end
				fbjs_pkg::ST_OUT_LD: out_valid_q <= 1'b1;
				fbjs_pkg::ST_OUT_WAIT: begin
					if (out_ready) begin
						out_valid_q <= 1'b0;
						i_q         <= i_q + CW'(1);
					end
				end
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			delta_q <= delta_us;
			meas_q  <= measured_us;
			jidx_q  <= job_index;
		end
		if (mem_req.wr_en && (state_q == fbjs_pkg::ST_TK_MOD || state_q == fbjs_pkg::ST_TK_JDIV)) begin
			key_q[i_q[JW-1:0]] <= el_add;
		end
		if (state_q == fbjs_pkg::ST_RK_LD) begin
			keyi_q <= key_rd;
		end
		if (state_q == fbjs_pkg::ST_RK_CMP && j_last) begin
			order_q[rank_new[JW-1:0]] <= i_q[JW-1:0];
		end
		if (state_q == fbjs_pkg::ST_OUT_LD) begin
			out_job_q   <= 3'(i_q);
			run_count_q <= rec.grant;
			last_q      <= i_last;
		end
	end

	assign out_valid = out_valid_q;
	assign out_job   = out_job_q;
	assign run_count = run_count_q;
	assign last      = last_q;

	`FBJS_ASSERT_NEVER(a_ready_vs_result, in_ready && out_valid, "input ready while a result is pending")
	`FBJS_ASSERT_IMP(a_last_is_final, out_valid && last, (CW'(out_job) + CW'(1)) == n_jobs, "last flag on a result that is not the final job")
	`FBJS_ASSERT_IMP(a_div_owner, div_done, state_q == fbjs_pkg::ST_TK_SDIV || state_q == fbjs_pkg::ST_TK_JDIV, "divider finished outside an averaging step")

endmodule
`default_nettype wire

FILE: rtl/core/fbjs_mem.sv
`default_nettype none
module fbjs_mem (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire fbjs_pkg::mem_req_t req,
	output fbjs_pkg::job_rec_t     rd_data
);

	fbjs_pkg::job_rec_t mem_q [fbjs_pkg::MAX_JOBS];
	logic [fbjs_pkg::MAX_JOBS-1:0] valid_q;
	fbjs_pkg::job_rec_t rd_q;
	logic rd_valid_q;

	always_ff @(posedge clk) begin
		if (req.wr_en) begin
			mem_q[req.wr_addr] <= req.wr_data;
		end
		if (req.rd_en) begin
			rd_q <= mem_q[req.rd_addr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
			rd_valid_q <= 1'b0;
		end else begin
			if (req.wr_en) begin
				valid_q[req.wr_addr] <= 1'b1;
			end
			if (req.rd_en) begin
				rd_valid_q <= valid_q[req.rd_addr];
			end
		end
	end

	// unwritten entries read as zero
	assign rd_data = rd_valid_q ? rd_q : '0;

endmodule
`default_nettype wire

FILE: rtl/core/fbjs_div.sv
`default_nettype none
module fbjs_div (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        start,
	input  wire logic [31:0] dividend,
	input  wire logic [15:0] divisor,
	output logic             done,
	output logic [31:0]      quotient
);

	logic        busy_q;
	logic        done_q;
	logic [4:0]  cnt_q;
	logic [15:0] rem_q;
	logic [31:0] quo_q;
	logic [15:0] dvs_q;
	logic [16:0] trial;
	logic        fits;

	assign trial = {rem_q, quo_q[31]};
	assign fits  = trial >= {1'b0, dvs_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 5'd1;
				if (cnt_q == 5'd31) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// restoring division, one quotient bit per cycle
	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			quo_q <= dividend;
			dvs_q <= divisor;
		end else if (busy_q) begin
			rem_q <= fits ? 16'(trial - {1'b0, dvs_q}) : trial[15:0];
			quo_q <= {quo_q[30:0], fits};
		end
	end

	assign done     = done_q;
	assign quotient = quo_q;

endmodule
`default_nettype wire
